[hdl/pwv_pkg.sv]
package pwv_pkg;

	localparam int NOTE_W     = 7;
	localparam int PHASE_W    = 32;
	localparam int WAVE_W     = 2;
	localparam int DEPTH_W    = 7;
	localparam int ATK_W      = 6;
	localparam int CUT_W      = 11;
	localparam int ENV_W      = 11;
	localparam int FILT_W     = 12;
	localparam int SAMPLE_W   = 8;
	localparam int COUNT_W    = 4;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int QUO_W      = 23;

	localparam logic [ENV_W-1:0]   ENV_MAX    = 11'd1024;
	localparam logic [ENV_W-1:0]   ENV_REL    = 11'd10;
	localparam logic [PHASE_W-1:0] LFO_STEP   = 32'd12000;
	// floor(2^41 / 1000); the estimate is low by at most one.
	localparam logic [PHASE_W-1:0] RECIP_1000 = 32'd2199023255;
	localparam int                 RECIP_SH   = 41;
	localparam logic [9:0]         DIV_1000   = 10'd1000;

	localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WOBBLE   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF   = 4'd3;

	localparam logic [WAVE_W-1:0]  WAVE_RESET   = 2'd0;
	localparam logic [DEPTH_W-1:0] DEPTH_RESET  = 7'd0;
	localparam logic [ATK_W-1:0]   ATK_RESET    = 6'd12;
	localparam logic [CUT_W-1:0]   CUT_RESET    = 11'd650;

	typedef enum logic [1:0] {
		CMD_TICK     = 2'd0,
		CMD_NOTE_ON  = 2'd1,
		CMD_NOTE_OFF = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		SHAPE_SINE  = 2'd0,
		SHAPE_PULSE = 2'd1,
		SHAPE_TRI   = 2'd2,
		SHAPE_RAMP  = 2'd3
	} wave_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LFO, ST_ENV, ST_RECIP, ST_QFIX, ST_WOB, ST_PHASE, ST_SHAPE,
		ST_ACC, ST_DIVLD, ST_DIV, ST_FMUL, ST_FOUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_NOTE_ON, OP_NOTE_OFF, OP_LFO, OP_ENV, OP_RECIP, OP_QFIX,
		OP_WOB, OP_PHASE, OP_SHAPE, OP_ACC, OP_DIV_LOAD, OP_DIV_STEP,
		OP_FILT_MUL, OP_FILT_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic voice_live;
		logic last_voice;
		logic div_last;
		logic out_free;
	} dp_stat_t;

	// 127*sin(k*pi/128) truncated, k = 0..64
	localparam logic [6:0] QSINE [0:64] = '{
		7'd0, 7'd3, 7'd6, 7'd9, 7'd12, 7'd15, 7'd18, 7'd21,
		7'd24, 7'd27, 7'd30, 7'd33, 7'd36, 7'd39, 7'd42, 7'd45,
		7'd48, 7'd51, 7'd54, 7'd57, 7'd59, 7'd62, 7'd65, 7'd67,
		7'd70, 7'd73, 7'd75, 7'd78, 7'd80, 7'd82, 7'd85, 7'd87,
		7'd89, 7'd91, 7'd94, 7'd96, 7'd98, 7'd100, 7'd102, 7'd103,
		7'd105, 7'd107, 7'd108, 7'd110, 7'd112, 7'd113, 7'd114, 7'd116,
		7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122, 7'd123, 7'd123,
		7'd124, 7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd126, 7'd126,
		7'd127
	};

	// Signed sine sample from the quarter-wave ROM, in -127..127.
	function automatic logic signed [7:0] sine_sample(input logic [7:0] idx);
		logic [6:0] k;
		logic [6:0] m;
		logic [7:0] mag;
		k = idx[6:0];
		m = (k <= 7'd64) ? k : 7'(8'd128 - {1'b0, k});
		mag = {1'b0, QSINE[m]};
		if (!idx[7])
			sine_sample = $signed(mag);
		else if (m == 7'd0)
			sine_sample = 8'sd0;
		else if (m == 7'd64)
			sine_sample = -8'sd127;
		else
			sine_sample = $signed(8'(~mag));
	endfunction

	function automatic logic signed [7:0] wave_sample(input logic [1:0] sel,
			input logic [7:0] idx);
		logic [14:0] tx;
		logic [32:0] tp;
		logic [11:0] sx;
		logic [27:0] sp;
		logic [8:0]  q;
		logic signed [9:0] r;
		tx = 15'(idx[6:0]) * 15'd240;
		tp = 33'(tx) * 33'd132105;
		sx = {idx, 4'b0000};
		sp = 28'(sx) * 28'd61681;
		q = 9'd0;
		r = 10'sd0;
		case (sel)
			SHAPE_SINE: r = 10'(sine_sample(idx));
			SHAPE_PULSE: r = idx[7] ? -10'sd120 : 10'sd120;
			SHAPE_TRI: begin
				q = {1'b0, tp[31:24]};
				r = idx[7] ? 10'sd120 - $signed({1'b0, q}) : $signed({1'b0, q}) - 10'sd120;
			end
			SHAPE_RAMP: begin
				q = {1'b0, sp[27:20]};
				r = $signed({1'b0, q}) - 10'sd120;
			end
			default: r = 10'sd0;
		endcase
		wave_sample = r[7:0];
	endfunction

endpackage

[hdl/pwv_if.sv]
interface pwv_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     command;
	logic [pwv_pkg::NOTE_W-1:0]     note;
	logic [pwv_pkg::PHASE_W-1:0]    phase_step;
	modport source (output valid, command, note, phase_step, input ready);
	modport sink (input valid, command, note, phase_step, output ready);
endinterface

interface pwv_res_if;
	logic                           valid;
	logic                           ready;
	logic [pwv_pkg::SAMPLE_W-1:0]   sample;
	logic [pwv_pkg::COUNT_W-1:0]    voices_sounding;
	modport source (output valid, sample, voices_sounding, input ready);
	modport sink (input valid, sample, voices_sounding, output ready);
endinterface

interface pwv_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [pwv_pkg::CFG_IDX_W-1:0]  index;
	logic [pwv_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hdl/pwv_ctrl.sv]
module pwv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_command,
	output logic              in_ready,
	input  pwv_pkg::dp_stat_t stat,
	output pwv_pkg::dp_cmd_t  cmd
);

	pwv_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= pwv_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		cmd.op = pwv_pkg::OP_NONE;
		case (state_q)
			pwv_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_command)
						pwv_pkg::CMD_TICK: state_d = pwv_pkg::ST_LFO;
						pwv_pkg::CMD_NOTE_ON: cmd.op = pwv_pkg::OP_NOTE_ON;
						pwv_pkg::CMD_NOTE_OFF: cmd.op = pwv_pkg::OP_NOTE_OFF;
						default: cmd.op = pwv_pkg::OP_NONE;
					endcase
				end
			end
			pwv_pkg::ST_LFO: begin
				cmd.op = pwv_pkg::OP_LFO;
				state_d = pwv_pkg::ST_ENV;
			end
			pwv_pkg::ST_ENV: begin
				cmd.op = pwv_pkg::OP_ENV;
				if (stat.voice_live)
					state_d = pwv_pkg::ST_RECIP;
				else if (stat.last_voice)
					state_d = pwv_pkg::ST_DIVLD;
			end
			pwv_pkg::ST_RECIP: begin
				cmd.op = pwv_pkg::OP_RECIP;
				state_d = pwv_pkg::ST_QFIX;
			end
			pwv_pkg::ST_QFIX: begin
				cmd.op = pwv_pkg::OP_QFIX;
				state_d = pwv_pkg::ST_WOB;
			end
			pwv_pkg::ST_WOB: begin
				cmd.op = pwv_pkg::OP_WOB;
				state_d = pwv_pkg::ST_PHASE;
			end
			pwv_pkg::ST_PHASE: begin
				cmd.op = pwv_pkg::OP_PHASE;
				state_d = pwv_pkg::ST_SHAPE;
			end
			pwv_pkg::ST_SHAPE: begin
				cmd.op = pwv_pkg::OP_SHAPE;
				state_d = pwv_pkg::ST_ACC;
			end
			pwv_pkg::ST_ACC: begin
				cmd.op = pwv_pkg::OP_ACC;
				state_d = stat.last_voice ? pwv_pkg::ST_DIVLD : pwv_pkg::ST_ENV;
			end
			pwv_pkg::ST_DIVLD: begin
				cmd.op = pwv_pkg::OP_DIV_LOAD;
				state_d = pwv_pkg::ST_DIV;
			end
			pwv_pkg::ST_DIV: begin
				cmd.op = pwv_pkg::OP_DIV_STEP;
				if (stat.div_last)
					state_d = pwv_pkg::ST_FMUL;
			end
			pwv_pkg::ST_FMUL: begin
				cmd.op = pwv_pkg::OP_FILT_MUL;
				state_d = pwv_pkg::ST_FOUT;
			end
			pwv_pkg::ST_FOUT: begin
				// Wait here until the output register can take the sample.
				if (stat.out_free) begin
					cmd.op = pwv_pkg::OP_FILT_OUT;
					state_d = pwv_pkg::ST_IDLE;
				end
			end
			default: state_d = pwv_pkg::ST_IDLE;
		endcase
	end

endmodule

[hdl/pwv_datapath.sv]
module pwv_datapath #(
	parameter int VOICES = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pwv_pkg::dp_cmd_t               cmd,
	output pwv_pkg::dp_stat_t              stat,
	input  logic [pwv_pkg::NOTE_W-1:0]     in_note,
	input  logic [pwv_pkg::PHASE_W-1:0]    in_step,
	input  logic                           cfg_we,
	input  logic [pwv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pwv_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [pwv_pkg::SAMPLE_W-1:0]   res_sample,
	output logic [pwv_pkg::COUNT_W-1:0]    res_count
);

	localparam int VW  = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CW  = $clog2(VOICES + 1);
	localparam int MW  = 8 + CW;
	localparam int DCW = $clog2(MW);

	logic                          active_q [VOICES];
	logic                          gate_q   [VOICES];
	logic [pwv_pkg::NOTE_W-1:0]    note_q   [VOICES];
	logic [pwv_pkg::PHASE_W-1:0]   phase_q  [VOICES];
	logic [pwv_pkg::PHASE_W-1:0]   step_q   [VOICES];
	logic [pwv_pkg::ENV_W-1:0]     env_q    [VOICES];

	logic [pwv_pkg::PHASE_W-1:0]   lfo_q;
	logic signed [pwv_pkg::FILT_W-1:0] filt_q;
	logic [pwv_pkg::WAVE_W-1:0]    wave_q;
	logic [pwv_pkg::DEPTH_W-1:0]   depth_q;
	logic [pwv_pkg::ATK_W-1:0]     atk_q;
	logic [pwv_pkg::CUT_W-1:0]     cut_q;

	logic [VW-1:0]                 vidx_q;
	logic signed [7:0]             wob_q;
	logic [pwv_pkg::QUO_W-1:0]     prod_q;
	logic [pwv_pkg::QUO_W-1:0]     q0_q;
	logic [pwv_pkg::PHASE_W-1:0]   chk_q;
	logic [pwv_pkg::QUO_W-1:0]     quo_q;
	logic [pwv_pkg::PHASE_W-1:0]   qw_q;
	logic signed [18:0]            sp_q;
	logic signed [MW-1:0]          mix_q;
	logic [CW-1:0]                 cnt_q;
	logic [MW-1:0]                 dq_q;
	logic [CW-1:0]                 rem_q;
	logic [DCW-1:0]                dcnt_q;
	logic                          neg_q;
	logic signed [27:0]            fprod_q;
	logic                          res_valid_q;
	logic [pwv_pkg::SAMPLE_W-1:0]  res_sample_q;
	logic [pwv_pkg::COUNT_W-1:0]   res_count_q;

	// Note lookup over all voices.
	logic          hit;
	logic [VW-1:0] hit_idx;
	logic [VW-1:0] free_idx;

	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		free_idx = '0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (active_q[i] && note_q[i] == in_note) begin
				hit = 1'b1;
				hit_idx = VW'(i);
			end
			if (!active_q[i])
				free_idx = VW'(i);
		end
	end

	// Current voice.
	logic [pwv_pkg::PHASE_W-1:0] step_cur, phase_cur;
	logic [pwv_pkg::ENV_W-1:0]   env_cur, env_up;
	logic [pwv_pkg::ENV_W:0]     env_sum;
	logic                        live, last;

	assign step_cur  = step_q[vidx_q];
	assign phase_cur = phase_q[vidx_q];
	assign env_cur   = env_q[vidx_q];
	assign env_sum   = {1'b0, env_cur} + {{(pwv_pkg::ENV_W + 1 - pwv_pkg::ATK_W){1'b0}}, atk_q};
	assign env_up    = (env_sum > {1'b0, pwv_pkg::ENV_MAX}) ? pwv_pkg::ENV_MAX
		: env_sum[pwv_pkg::ENV_W-1:0];
	assign live = active_q[vidx_q] && (gate_q[vidx_q] || env_cur > pwv_pkg::ENV_REL);
	assign last = (vidx_q == VW'(VOICES - 1));

	// LFO and wobble.
	logic [pwv_pkg::PHASE_W-1:0] lfo_next;
	logic signed [7:0]           lfo_s;
	logic signed [15:0]          lfo_p, lfo_pa;
	assign lfo_next = lfo_q + pwv_pkg::LFO_STEP;
	assign lfo_s    = pwv_pkg::sine_sample(lfo_next[31:24]);
	assign lfo_p    = lfo_s * $signed({1'b0, depth_q});
	assign lfo_pa   = lfo_p[15] ? lfo_p + 16'sd127 : lfo_p;

	// Divide by 1000 and bend.
	logic [63:0]                 recip_p;
	logic [pwv_pkg::PHASE_W-1:0] rem1000;
	logic [pwv_pkg::PHASE_W-1:0] wob_ext;
	assign recip_p = 64'(step_cur) * 64'(pwv_pkg::RECIP_1000);
	assign rem1000 = step_cur - chk_q;
	assign wob_ext = {{(pwv_pkg::PHASE_W - 8){wob_q[7]}}, wob_q};

	// Shape and scale.
	logic signed [7:0]  wav;
	logic signed [18:0] sp_adj;
	logic signed [18:0] sc_full;
	assign wav     = pwv_pkg::wave_sample(wave_q, phase_cur[31:24]);
	assign sp_adj  = sp_q[18] ? sp_q + 19'sd1023 : sp_q;
	assign sc_full = sp_adj >>> 10;

	// Divider step.
	logic [CW:0]   trial;
	logic          ge;
	logic [MW-1:0] mag;
	assign trial = {rem_q, dq_q[MW-1]};
	assign ge    = (trial >= {1'b0, cnt_q});
	assign mag   = mix_q[MW-1] ? MW'(-mix_q) : MW'(mix_q);

	// Filter.
	logic signed [MW-1:0] quo_s, mixf;
	logic signed [15:0]   diff;
	logic signed [27:0]   fadj_full;
	logic signed [18:0]   ysum;
	logic signed [pwv_pkg::FILT_W-1:0] ysat;
	logic signed [12:0]   outv;
	logic [pwv_pkg::SAMPLE_W-1:0] outc;
	assign quo_s = neg_q ? $signed(MW'(-dq_q)) : $signed(dq_q);
	assign mixf  = (cnt_q > CW'(1)) ? quo_s : mix_q;
	assign diff  = {{(16 - MW){mixf[MW-1]}}, mixf} - {{4{filt_q[pwv_pkg::FILT_W-1]}}, filt_q};
	assign fadj_full = (fprod_q[27] ? fprod_q + 28'sd1023 : fprod_q) >>> 10;
	assign ysum = {{7{filt_q[pwv_pkg::FILT_W-1]}}, filt_q} + fadj_full[18:0];

	always_comb begin
		if (ysum > 19'sd2047)
			ysat = 12'sd2047;
		else if (ysum < -19'sd2048)
			ysat = -12'sd2048;
		else
			ysat = ysum[pwv_pkg::FILT_W-1:0];
		outv = {ysat[pwv_pkg::FILT_W-1], ysat} + 13'sd128;
		if (outv < 13'sd0)
			outc = '0;
		else if (outv > 13'sd255)
			outc = '1;
		else
			outc = outv[pwv_pkg::SAMPLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICES; i++) begin
				active_q[i] <= 1'b0;
				gate_q[i]   <= 1'b0;
				note_q[i]   <= '0;
				phase_q[i]  <= '0;
				step_q[i]   <= '0;
				env_q[i]    <= '0;
			end
			lfo_q       <= '0;
			filt_q      <= '0;
			wave_q      <= pwv_pkg::WAVE_RESET;
			depth_q     <= pwv_pkg::DEPTH_RESET;
			atk_q       <= pwv_pkg::ATK_RESET;
			cut_q       <= pwv_pkg::CUT_RESET;
			vidx_q      <= '0;
			cnt_q       <= '0;
			dcnt_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pwv_pkg::REG_WAVEFORM: wave_q <= cfg_data[pwv_pkg::WAVE_W-1:0];
					pwv_pkg::REG_WOBBLE: depth_q <= cfg_data[pwv_pkg::DEPTH_W-1:0];
					pwv_pkg::REG_ATTACK: atk_q <= cfg_data[pwv_pkg::ATK_W-1:0];
					pwv_pkg::REG_CUTOFF: cut_q <= cfg_data[pwv_pkg::CUT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.op == pwv_pkg::OP_FILT_OUT)
				res_valid_q <= 1'b1;
			else if (res_valid_q && res_ready)
				res_valid_q <= 1'b0;
			case (cmd.op)
				pwv_pkg::OP_NOTE_ON: begin
					if (hit) begin
						gate_q[hit_idx] <= 1'b1;
					end else begin
						active_q[free_idx] <= 1'b1;
						gate_q[free_idx]   <= 1'b1;
						note_q[free_idx]   <= in_note;
						phase_q[free_idx]  <= '0;
						step_q[free_idx]   <= in_step;
						env_q[free_idx]    <= '0;
					end
				end
				pwv_pkg::OP_NOTE_OFF: begin
					if (hit)
						gate_q[hit_idx] <= 1'b0;
				end
				pwv_pkg::OP_LFO: begin
					lfo_q  <= lfo_next;
					wob_q  <= lfo_pa[14:7];
					vidx_q <= '0;
					cnt_q  <= '0;
					mix_q  <= '0;
				end
				pwv_pkg::OP_ENV: begin
					if (active_q[vidx_q]) begin
						if (gate_q[vidx_q]) begin
							env_q[vidx_q] <= env_up;
						end else if (env_cur > pwv_pkg::ENV_REL) begin
							env_q[vidx_q] <= env_cur - pwv_pkg::ENV_REL;
						end else begin
							env_q[vidx_q]    <= '0;
							active_q[vidx_q] <= 1'b0;
						end
					end
					if (!live)
						vidx_q <= vidx_q + VW'(1);
					prod_q <= recip_p[pwv_pkg::RECIP_SH +: pwv_pkg::QUO_W];
				end
				pwv_pkg::OP_RECIP: begin
					q0_q  <= prod_q;
					chk_q <= 32'(prod_q) * 32'(pwv_pkg::DIV_1000);
				end
				pwv_pkg::OP_QFIX: begin
					quo_q <= q0_q + pwv_pkg::QUO_W'(rem1000 >= 32'(pwv_pkg::DIV_1000));
				end
				pwv_pkg::OP_WOB: begin
					qw_q <= 32'({{(pwv_pkg::PHASE_W - pwv_pkg::QUO_W){1'b0}}, quo_q} * wob_ext);
				end
				pwv_pkg::OP_PHASE: begin
					phase_q[vidx_q] <= phase_cur + step_cur + qw_q;
				end
				pwv_pkg::OP_SHAPE: begin
					sp_q <= wav * $signed({1'b0, env_cur});
				end
				pwv_pkg::OP_ACC: begin
					mix_q  <= mix_q + {{(MW - 9){sc_full[8]}}, sc_full[8:0]};
					cnt_q  <= cnt_q + CW'(1);
					vidx_q <= vidx_q + VW'(1);
				end
				pwv_pkg::OP_DIV_LOAD: begin
					neg_q  <= mix_q[MW-1];
					dq_q   <= mag;
					rem_q  <= '0;
					dcnt_q <= DCW'(MW - 1);
				end
				pwv_pkg::OP_DIV_STEP: begin
					rem_q  <= ge ? CW'(trial - {1'b0, cnt_q}) : trial[CW-1:0];
					dq_q   <= {dq_q[MW-2:0], ge};
					dcnt_q <= dcnt_q - DCW'(1);
				end
				pwv_pkg::OP_FILT_MUL: begin
					fprod_q <= diff * $signed({1'b0, cut_q});
				end
				pwv_pkg::OP_FILT_OUT: begin
					filt_q       <= ysat;
					res_sample_q <= outc;
					res_count_q  <= pwv_pkg::COUNT_W'(cnt_q);
				end
				default: ;
			endcase
		end
	end

	assign stat.voice_live = live;
	assign stat.last_voice = last;
	assign stat.div_last   = (dcnt_q == '0);
	assign stat.out_free   = !res_valid_q || res_ready;

	assign res_valid  = res_valid_q;
	assign res_sample = res_sample_q;
	assign res_count  = res_count_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(VOICES))
		else $error("voice count exceeds the number of voices");

	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		env_q[vidx_q] <= pwv_pkg::ENV_MAX)
		else $error("envelope above full scale");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == pwv_pkg::OP_FILT_OUT |=> res_valid_q)
		else $error("finished sample did not reach the output register");

	a_out_space: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == pwv_pkg::OP_FILT_OUT |-> (!res_valid_q || res_ready))
		else $error("output register overwritten before it was taken");

endmodule

[hdl/polyphonic_wavetable_voice_engine.sv]
// Note on, note off and unknown commands are each handled in the idle state.
// A sample tick runs every voice through the shared per-voice datapath, then
// averages the mix with the bit-serial divider and filters it.
// Reset clears all voices, the LFO and the filter, and loads the register defaults.
module polyphonic_wavetable_voice_engine #(
	parameter int VOICES = 8
) (
	input logic        clk,
	input logic        arst_n,
	pwv_cmd_if.sink    cmd_ch,
	pwv_res_if.source  res_ch,
	pwv_cfg_if.sink    cfg_ch
);

	pwv_pkg::dp_cmd_t  dp_cmd;
	pwv_pkg::dp_stat_t dp_stat;

	assign cfg_ch.ready = 1'b1;

	pwv_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (cmd_ch.valid),
		.in_command (cmd_ch.command),
		.in_ready   (cmd_ch.ready),
		.stat       (dp_stat),
		.cmd        (dp_cmd)
	);

	pwv_datapath #(
		.VOICES (VOICES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dp_cmd),
		.stat       (dp_stat),
		.in_note    (cmd_ch.note),
		.in_step    (cmd_ch.phase_step),
		.cfg_we     (cfg_ch.valid),
		.cfg_index  (cfg_ch.index),
		.cfg_data   (cfg_ch.data),
		.res_valid  (res_ch.valid),
		.res_ready  (res_ch.ready),
		.res_sample (res_ch.sample),
		.res_count  (res_ch.voices_sounding)
	);

endmodule

[dv/tb_pwv_if.sv]
`timescale 1ns / 100ps
// Free-running bench clock with a 10 ns period.
module tb_pwv_clkgen (output logic clk);
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end
endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;

	localparam int NV = 8;

	typedef struct {
		pwv_pkg::cmd_code_t cmd;
		logic [6:0]       note;
		logic [31:0]      step;
		logic             known;
		logic [7:0]       sample;
		logic [3:0]       count;
	} stim_row_t;

	typedef struct {
		logic [7:0] sample;
		logic [3:0] count;
		logic       known;
		logic [7:0] k_sample;
		logic [3:0] k_count;
	} audio_exp_t;

	logic clk;
	logic arst_n;
	bit   failed = 1'b0;
	bit   rx_quiet;

	tb_pwv_clkgen u_clk (.clk(clk));

	pwv_cmd_if cmd_ch ();
	pwv_res_if res_ch ();
	pwv_cfg_if cfg_ch ();

	polyphonic_wavetable_voice_engine #(.VOICES(NV)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_ch(cmd_ch.sink),
		.res_ch(res_ch.source),
		.cfg_ch(cfg_ch.sink)
	);

	// Voice and effect state of the synth, as the bench tracks it.
	bit          v_active [NV];
	bit          v_gate [NV];
	logic [6:0]  v_note [NV];
	logic [31:0] v_phase [NV];
	logic [31:0] v_step [NV];
	int          v_env [NV];
	logic [31:0] lfo_ph;
	int          filt_y;
	logic [1:0]  r_wave;
	logic [6:0]  r_depth;
	logic [5:0]  r_attack;
	logic [10:0] r_cutoff;

	audio_exp_t audio_q[$];

	function automatic int sine_val(int idx);
		int q[65] = '{0, 3, 6, 9, 12, 15, 18, 21, 24, 27, 30, 33, 36, 39, 42, 45,
			48, 51, 54, 57, 59, 62, 65, 67, 70, 73, 75, 78, 80, 82, 85, 87,
			89, 91, 94, 96, 98, 100, 102, 103, 105, 107, 108, 110, 112, 113, 114, 116,
			117, 118, 119, 120, 121, 122, 123, 123, 124, 125, 125, 126, 126, 126, 126,
			126, 127};
		int k;
		int m;
		k = idx & 127;
		m = (k <= 64) ? k : 128 - k;
		if (idx < 128)
			return q[m];
		if (m == 0)
			return 0;
		if (m == 64)
			return -127;
		return -1 - q[m];
	endfunction

	function automatic int shape_val(logic [1:0] sel, int i);
		case (pwv_pkg::wave_t'(sel))
			pwv_pkg::SHAPE_SINE: return sine_val(i);
			pwv_pkg::SHAPE_PULSE: return i < 128 ? 120 : -120;
			pwv_pkg::SHAPE_TRI: return i < 128 ? (i * 240) / 127 - 120
				: 120 - ((i - 128) * 240) / 127;
			default: return (i * 240) / 255 - 120;
		endcase
	endfunction

	function automatic int hold_voice(logic [6:0] n);
		for (int i = 0; i < NV; i++)
			if (v_active[i] && v_note[i] == n)
				return i;
		return -1;
	endfunction

	task automatic clear_voices();
		for (int i = 0; i < NV; i++) begin
			v_active[i] = 0;
			v_gate[i] = 0;
			v_note[i] = 0;
			v_phase[i] = 0;
			v_step[i] = 0;
			v_env[i] = 0;
		end
		lfo_ph = 0;
		filt_y = 0;
		r_wave = pwv_pkg::WAVE_RESET;
		r_depth = pwv_pkg::DEPTH_RESET;
		r_attack = pwv_pkg::ATK_RESET;
		r_cutoff = pwv_pkg::CUT_RESET;
	endtask

	// Advances the synth by one item; returns 1 and the audio out for a tick.
	function automatic bit synth_item(pwv_pkg::cmd_code_t c, logic [6:0] n,
			logic [31:0] st, output logic [7:0] smp, output logic [3:0] cnt);
		int v;
		int mix;
		int count;
		int lfo;
		int wob;
		int s;
		int y;
		logic [31:0] inc;
		smp = 0;
		cnt = 0;
		case (c)
			pwv_pkg::CMD_NOTE_ON: begin
				v = hold_voice(n);
				if (v >= 0) begin
					v_gate[v] = 1;
					return 0;
				end
				v = 0;
				for (int i = NV - 1; i >= 0; i--)
					if (!v_active[i])
						v = i;
				v_active[v] = 1;
				v_gate[v] = 1;
				v_note[v] = n;
				v_phase[v] = 0;
				v_step[v] = st;
				v_env[v] = 0;
				return 0;
			end
			pwv_pkg::CMD_NOTE_OFF: begin
				v = hold_voice(n);
				if (v >= 0)
					v_gate[v] = 0;
				return 0;
			end
			pwv_pkg::CMD_TICK: ;
			default: return 0;
		endcase
		mix = 0;
		count = 0;
		lfo_ph = lfo_ph + pwv_pkg::LFO_STEP;
		lfo = sine_val(int'(lfo_ph[31:24]));
		wob = (lfo * int'(r_depth)) / 128;
		for (int i = 0; i < NV; i++) begin
			if (!v_active[i])
				continue;
			if (v_gate[i]) begin
				v_env[i] += int'(r_attack);
				if (v_env[i] > 1024)
					v_env[i] = 1024;
			end else begin
				v_env[i] -= 10;
				if (v_env[i] <= 0) begin
					v_env[i] = 0;
					v_active[i] = 0;
					continue;
				end
			end
			inc = v_step[i] + (v_step[i] / 32'd1000) * 32'(wob);
			v_phase[i] = v_phase[i] + inc;
			s = shape_val(r_wave, int'(v_phase[i][31:24]));
			mix += (s * v_env[i]) / 1024;
			count++;
		end
		if (count > 1)
			mix = mix / count;
		y = filt_y + ((mix - filt_y) * int'(r_cutoff)) / 1024;
		if (y > 2047)
			y = 2047;
		if (y < -2048)
			y = -2048;
		filt_y = y;
		y = 128 + y;
		if (y < 0)
			y = 0;
		if (y > 255)
			y = 255;
		smp = y[7:0];
		cnt = count[3:0];
		return 1;
	endfunction

	// Leaves valid high with the old item; the next call or drain replaces it
	// at the same falling edge.
	task automatic send_cmd(pwv_pkg::cmd_code_t c, logic [6:0] n, logic [31:0] st,
			bit known, logic [7:0] ks, logic [3:0] kc, bit gaps);
		audio_exp_t e;
		while (gaps && $urandom_range(99) < 15) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= c;
		cmd_ch.note <= n;
		cmd_ch.phase_step <= st;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		if (synth_item(c, n, st, e.sample, e.count)) begin
			e.known = known;
			e.k_sample = ks;
			e.k_count = kc;
			audio_q.push_back(e);
		end
		@(negedge clk);
	endtask

	task automatic write_reg(logic [pwv_pkg::CFG_IDX_W-1:0] idx, logic [15:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= d;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			pwv_pkg::REG_WAVEFORM: r_wave = d[1:0];
			pwv_pkg::REG_WOBBLE: r_depth = d[6:0];
			pwv_pkg::REG_ATTACK: r_attack = d[5:0];
			pwv_pkg::REG_CUTOFF: r_cutoff = d[10:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (audio_q.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	// Result side: random backpressure (none while rx_quiet is set) and an in-order compare.
	always @(negedge clk) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else
			res_ch.ready <= rx_quiet ? 1'b1 : ($urandom_range(99) >= 15);
	end

	always @(posedge clk) begin
		audio_exp_t e;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (audio_q.size() == 0) begin
				$display("%0t: unexpected item sample=%0d count=%0d", $time,
					res_ch.sample, res_ch.voices_sounding);
				failed = 1;
			end else begin
				e = audio_q.pop_front();
				if (e.known && (e.k_sample != e.sample || e.k_count != e.count)) begin
					$display("%0t: table/predictor disagree exp=%0d/%0d pred=%0d/%0d",
						$time, e.k_sample, e.k_count, e.sample, e.count);
					failed = 1;
				end
				if (res_ch.sample !== e.sample) begin
					$display("%0t: sample exp=%0d act=%0d", $time, e.sample,
						res_ch.sample);
					failed = 1;
				end
				if (res_ch.voices_sounding !== e.count) begin
					$display("%0t: voices_sounding exp=%0d act=%0d", $time, e.count,
						res_ch.voices_sounding);
					failed = 1;
				end
			end
		end
	end

	stim_row_t dir_tab[] = '{
		'{pwv_pkg::CMD_TICK, 7'd0, 32'd0, 1'b1, 8'd128, 4'd0},
		'{pwv_pkg::CMD_NONE, 7'd127, 32'hFFFF_FFFF, 1'b0, 8'd0, 4'd0},
		'{pwv_pkg::CMD_NOTE_OFF, 7'd5, 32'd0, 1'b0, 8'd0, 4'd0},
		'{pwv_pkg::CMD_TICK, 7'd127, 32'hFFFF_FFFF, 1'b1, 8'd128, 4'd0},
		'{pwv_pkg::CMD_NOTE_ON, 7'd0, 32'hFFFF_FFFF, 1'b0, 8'd0, 4'd0},
		'{pwv_pkg::CMD_NOTE_ON, 7'd127, 32'h0100_0000, 1'b0, 8'd0, 4'd0},
		'{pwv_pkg::CMD_TICK, 7'd0, 32'd0, 1'b0, 8'd0, 4'd0},
		'{pwv_pkg::CMD_NOTE_ON, 7'd0, 32'd5, 1'b0, 8'd0, 4'd0},
		'{pwv_pkg::CMD_NOTE_ON, 7'd10, 32'h0080_0000, 1'b0, 8'd0, 4'd0},
		'{pwv_pkg::CMD_NOTE_ON, 7'd11, 32'h0233_0000, 1'b0, 8'd0, 4'd0},
		'{pwv_pkg::CMD_NOTE_ON, 7'd12, 32'h7FFF_FFFF, 1'b0, 8'd0, 4'd0},
		'{pwv_pkg::CMD_NOTE_ON, 7'd13, 32'h0055_5555, 1'b0, 8'd0, 4'd0},
		'{pwv_pkg::CMD_NOTE_ON, 7'd14, 32'h8000_0000, 1'b0, 8'd0, 4'd0},
		'{pwv_pkg::CMD_NOTE_ON, 7'd15, 32'h0004_0000, 1'b0, 8'd0, 4'd0},
		'{pwv_pkg::CMD_TICK, 7'd0, 32'd0, 1'b0, 8'd0, 4'd0},
		'{pwv_pkg::CMD_NOTE_ON, 7'd99, 32'h0111_0000, 1'b0, 8'd0, 4'd0},
		'{pwv_pkg::CMD_TICK, 7'd0, 32'd0, 1'b0, 8'd0, 4'd0},
		'{pwv_pkg::CMD_NOTE_OFF, 7'd99, 32'd0, 1'b0, 8'd0, 4'd0},
		'{pwv_pkg::CMD_NOTE_OFF, 7'd127, 32'd0, 1'b0, 8'd0, 4'd0},
		'{pwv_pkg::CMD_NOTE_OFF, 7'd10, 32'd0, 1'b0, 8'd0, 4'd0},
		'{pwv_pkg::CMD_TICK, 7'd0, 32'd0, 1'b0, 8'd0, 4'd0},
		'{pwv_pkg::CMD_TICK, 7'd0, 32'd0, 1'b0, 8'd0, 4'd0}
	};

	initial begin
		logic [6:0] n;
		int pick;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = pwv_pkg::CMD_TICK;
		cmd_ch.note = '0;
		cmd_ch.phase_step = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = pwv_pkg::REG_WAVEFORM;
		cfg_ch.data = '0;
		rx_quiet = 0;
		clear_voices();
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i])
			send_cmd(dir_tab[i].cmd, dir_tab[i].note, dir_tab[i].step,
				dir_tab[i].known, dir_tab[i].sample, dir_tab[i].count, 0);
		drain();

		// Eight phases of settings, extremes included; released voices die out
		// over about a hundred ticks, more than one phase of 125 items is likely to hold.
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(pwv_pkg::REG_WAVEFORM, 16'(ph % 4));
			write_reg(pwv_pkg::REG_WOBBLE, ph == 0 ? 16'd0 : ph == 1 ? 16'd80 :
				ph == 7 ? 16'd127 : 16'($urandom_range(80)));
			write_reg(pwv_pkg::REG_ATTACK, ph == 2 ? 16'd2 : ph == 3 ? 16'd40 :
				ph == 7 ? 16'd63 : 16'($urandom_range(40, 2)));
			write_reg(pwv_pkg::REG_CUTOFF, ph == 4 ? 16'd0 : ph == 5 ? 16'd1024 :
				ph == 7 ? 16'hFFFF : 16'($urandom_range(1024)));
			cfg_ch.valid <= 1'b0;
			rx_quiet = (ph == 3);
			for (int k = 0; k < 125; k++) begin
				pick = $urandom_range(99);
				n = (pick < 90) ? 7'($urandom_range(11)) : 7'($urandom);
				if (pick < 55)
					send_cmd(pwv_pkg::CMD_TICK, 7'($urandom), $urandom, 0, 0, 0, ph != 3);
				else if (pick < 78)
					send_cmd(pwv_pkg::CMD_NOTE_ON, n, $urandom, 0, 0, 0, ph != 3);
				else if (pick < 96)
					send_cmd(pwv_pkg::CMD_NOTE_OFF, n, $urandom, 0, 0, 0, ph != 3);
				else
					send_cmd(pwv_pkg::CMD_NONE, n, $urandom, 0, 0, 0, ph != 3);
			end
			rx_quiet = 0;
			drain();
		end

		if (!failed)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule
